// ===== design/dam_pkg.sv =====
`timescale 1ns / 1ps
// Package for the decimal accumulator machine core.
// Holds command, opcode and status codes, word limits and the word clamp.
// No dependencies.
package dam_pkg;

  // Host commands
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_EXECUTE = 2'd3;

  // Instruction opcodes
  localparam logic [6:0] OP_READ    = 7'd10;
  localparam logic [6:0] OP_WRITE   = 7'd11;
  localparam logic [6:0] OP_NEWLINE = 7'd12;
  localparam logic [6:0] OP_LOAD    = 7'd20;
  localparam logic [6:0] OP_STORE   = 7'd21;
  localparam logic [6:0] OP_ADD     = 7'd30;
  localparam logic [6:0] OP_SUB     = 7'd31;
  localparam logic [6:0] OP_DIV     = 7'd32;
  localparam logic [6:0] OP_MUL     = 7'd33;
  localparam logic [6:0] OP_REM     = 7'd34;
  localparam logic [6:0] OP_EXP     = 7'd35;
  localparam logic [6:0] OP_BRANCH  = 7'd40;
  localparam logic [6:0] OP_BRNEG   = 7'd41;
  localparam logic [6:0] OP_BRZERO  = 7'd42;
  localparam logic [6:0] OP_HALT    = 7'd43;

  // Result status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_OUTPUT   = 4'd1;
  localparam logic [3:0] ST_NEWLINE  = 4'd2;
  localparam logic [3:0] ST_HALTED   = 4'd3;
  localparam logic [3:0] ST_DIVZERO  = 4'd4;
  localparam logic [3:0] ST_OVERFLOW = 4'd5;
  localparam logic [3:0] ST_PASTEND  = 4'd6;
  localparam logic [3:0] ST_STOPPED  = 4'd7;
  localparam logic [3:0] ST_READDATA = 4'd8;

  localparam logic signed [17:0] WORD_MAX = 18'sd99999;
  localparam logic signed [17:0] WORD_MIN = -18'sd99999;

  // ceil(2^27 / 1000): word / 1000 as a multiply and shift
  localparam logic [17:0] DEC_RECIP = 18'd134218;
  localparam int          DEC_SHIFT = 27;

  typedef logic signed [17:0] word_t;

  // Saturate an 18-bit word to the decimal word range
  function automatic word_t clamp_word(input word_t v);
    word_t r;
    if (v > WORD_MAX) r = WORD_MAX;
    else if (v < WORD_MIN) r = WORD_MIN;
    else r = v;
    return r;
  endfunction

endpackage

// ===== design/decimal_accumulator_machine_core.sv =====
`timescale 1ns / 1ps
// Decimal accumulator machine core: word store in one synchronous RAM,
// a sequencer that fetches, decodes and executes one instruction per item.
// Depends on dam_pkg.
//
// A read word passes S_RDWORD; an instruction passes S_DEC1, S_DEC2, S_EXEC,
// then S_MULCHK for multiply, S_DIV (one quotient bit per cycle, 17 bits) and
// S_DIVFIX for divide/remainder, S_EXPMUL and S_EXPCHK per multiply step for
// exponent (at most about 17 steps before overflow). One item in flight; the
// next item is taken as its result is offered. After reset the RAM is cleared
// one word per cycle, in_stall high. Accumulator, pc cleared, machine running.
module decimal_accumulator_machine_core import dam_pkg::*; #(
  parameter int MEMORY_WORDS = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [9:0]         address,
  input  logic signed [17:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         status,
  output logic signed [17:0] out_value,
  output logic [9:0]         program_counter,
  output logic signed [17:0] accumulator_value
);

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEMORY_WORDS - 1);
  localparam logic [10:0]   MW11 = 11'(MEMORY_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDWORD, S_DEC1, S_DEC2, S_EXEC, S_MULCHK,
    S_EXPMUL, S_EXPCHK, S_DIV, S_DIVFIX, S_DONE
  } state_t;

  state_t state;

  // Word store
  word_t          mem [0:MEMORY_WORDS-1];
  word_t          rdata;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  word_t          mem_wdata;

  // Machine state
  word_t      acc;
  logic [9:0] pc;
  logic       stopped;

  // Item and decode registers
  logic [AW-1:0] clr_addr;
  word_t         value_q;
  logic          addr_ok_q;
  logic [16:0]   instr_q;
  logic [34:0]   dec_prod;
  logic [6:0]    opcode_q;
  logic [9:0]    operand_q;
  logic          op_ok_q;
  logic [3:0]    res_status;
  word_t         res_value;

  // Arithmetic units
  logic signed [35:0] prod;
  word_t              exp_r;
  word_t              m_q;
  logic [16:0]        exp_cnt;
  logic [16:0]        div_rem;
  logic [16:0]        div_dq;
  logic [16:0]        div_d;
  logic [4:0]         div_cnt;
  logic               div_qneg;
  logic               div_aneg;
  logic               div_isrem;

  // Combinational helpers
  logic               accept;
  logic               addr_ok;
  logic [6:0]         opcode_c;
  logic [16:0]        operand_c;
  word_t              m_c;
  logic signed [18:0] sum_c;
  logic [17:0]        div_sh;
  logic               div_ge;
  logic [9:0]         pc_inc;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign addr_ok  = ({1'b0, address} < MW11);
  assign opcode_c = dec_prod[DEC_SHIFT+6:DEC_SHIFT];
  assign operand_c = instr_q - 17'(opcode_c * 17'd1000);
  assign m_c      = op_ok_q ? rdata : '0;
  assign sum_c    = (opcode_q == OP_SUB) ? (19'(acc) - 19'(m_c)) : (19'(acc) + 19'(m_c));
  assign div_sh   = {div_rem, div_dq[16]};
  assign div_ge   = (div_sh >= {1'b0, div_d});
  assign pc_inc   = pc + 10'd1;

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_raddr = pc[AW-1:0];
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        if (command == CMD_READ) mem_raddr = address[AW-1:0];
        if (accept && command == CMD_WRITE && addr_ok) begin
          mem_we    = 1'b1;
          mem_waddr = address[AW-1:0];
          mem_wdata = clamp_word(value);
        end
      end
      S_DEC2: mem_raddr = operand_c[AW-1:0];
      S_EXEC: begin
        mem_waddr = operand_q[AW-1:0];
        mem_wdata = (opcode_q == OP_READ) ? value_q : acc;
        mem_we    = op_ok_q && (opcode_q == OP_READ || opcode_q == OP_STORE);
      end
      default: ;
    endcase
  end

  // Word store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      acc       <= '0;
      pc        <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            value_q    <= clamp_word(value);
            addr_ok_q  <= addr_ok;
            res_status <= ST_OK;
            res_value  <= '0;
            case (command)
              CMD_WRITE: state <= S_DONE;
              CMD_READ:  state <= S_RDWORD;
              CMD_RESTART: begin
                pc      <= '0;
                stopped <= 1'b0;
                state   <= S_DONE;
              end
              default: begin
                if (stopped) begin
                  res_status <= ST_STOPPED;
                  state      <= S_DONE;
                end else if ({1'b0, pc} >= MW11) begin
                  res_status <= ST_PASTEND;
                  stopped    <= 1'b1;
                  state      <= S_DONE;
                end else begin
                  state <= S_DEC1;
                end
              end
            endcase
          end
        end
        S_RDWORD: begin
          res_status <= ST_READDATA;
          res_value  <= addr_ok_q ? rdata : '0;
          state      <= S_DONE;
        end
        S_DEC1: begin
          // negative words are no-ops
          if (rdata[17]) begin
            pc    <= pc_inc;
            state <= S_DONE;
          end else begin
            instr_q  <= rdata[16:0];
            dec_prod <= 35'(rdata[16:0] * DEC_RECIP);
            state    <= S_DEC2;
          end
        end
        S_DEC2: begin
          opcode_q  <= opcode_c;
          operand_q <= operand_c[9:0];
          op_ok_q   <= (11'(operand_c[9:0]) < MW11);
          state     <= S_EXEC;
        end
        S_EXEC: begin
          pc    <= pc_inc;
          state <= S_DONE;
          m_q   <= m_c;
          case (opcode_q)
            OP_WRITE: begin
              res_status <= ST_OUTPUT;
              res_value  <= m_c;
            end
            OP_NEWLINE: res_status <= ST_NEWLINE;
            OP_LOAD:    acc <= m_c;
            OP_ADD, OP_SUB: begin
              if (sum_c > 19'sd99999 || sum_c < -19'sd99999) begin
                res_status <= ST_OVERFLOW;
                stopped    <= 1'b1;
              end else begin
                acc <= sum_c[17:0];
              end
            end
            OP_MUL: begin
              prod  <= 36'(acc) * 36'(m_c);
              pc    <= pc;
              state <= S_MULCHK;
            end
            OP_DIV, OP_REM: begin
              if (m_c == '0) begin
                res_status <= ST_DIVZERO;
                stopped    <= 1'b1;
              end else begin
                div_rem   <= '0;
                div_dq    <= acc[17] ? 17'(-acc) : acc[16:0];
                div_d     <= m_c[17] ? 17'(-m_c) : m_c[16:0];
                div_cnt   <= '0;
                div_qneg  <= acc[17] ^ m_c[17];
                div_aneg  <= acc[17];
                div_isrem <= (opcode_q == OP_REM);
                pc        <= pc;
                state     <= S_DIV;
              end
            end
            OP_EXP: begin
              // trivial bases and zero or negative exponents settle at once; others step until done or overflow
              if (m_c[17] || m_c == '0) acc <= 18'sd1;
              else if (acc == '0) acc <= '0;
              else if (acc == 18'sd1) acc <= 18'sd1;
              else if (acc == -18'sd1) acc <= m_c[0] ? -18'sd1 : 18'sd1;
              else begin
                exp_r   <= 18'sd1;
                exp_cnt <= '0;
                pc      <= pc;
                state   <= S_EXPMUL;
              end
            end
            OP_BRANCH: pc <= operand_q;
            OP_BRNEG:  if (acc[17]) pc <= operand_q;
            OP_BRZERO: if (acc == '0) pc <= operand_q;
            OP_HALT: begin
              res_status <= ST_HALTED;
              stopped    <= 1'b1;
            end
            default: ;
          endcase
        end
        S_MULCHK: begin
          if (prod > 36'sd99999 || prod < -36'sd99999) begin
            res_status <= ST_OVERFLOW;
            stopped    <= 1'b1;
          end else begin
            acc <= prod[17:0];
          end
          pc    <= pc_inc;
          state <= S_DONE;
        end
        S_EXPMUL: begin
          prod    <= 36'(exp_r) * 36'(acc);
          exp_cnt <= exp_cnt + 17'd1;
          state   <= S_EXPCHK;
        end
        S_EXPCHK: begin
          if (prod > 36'sd99999 || prod < -36'sd99999) begin
            res_status <= ST_OVERFLOW;
            stopped    <= 1'b1;
            pc         <= pc_inc;
            state      <= S_DONE;
          end else if (exp_cnt == m_q[16:0]) begin
            acc   <= prod[17:0];
            pc    <= pc_inc;
            state <= S_DONE;
          end else begin
            exp_r <= prod[17:0];
            state <= S_EXPMUL;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          div_rem <= div_ge ? 17'(div_sh - {1'b0, div_d}) : div_sh[16:0];
          div_dq  <= {div_dq[15:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd16) state <= S_DIVFIX;
        end
        S_DIVFIX: begin
          if (div_isrem) acc <= div_aneg ? -18'(div_rem) : 18'(div_rem);
          else           acc <= div_qneg ? -18'(div_dq) : 18'(div_dq);
          pc    <= pc_inc;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            status            <= res_status;
            out_value         <= res_value;
            program_counter   <= pc;
            accumulator_value <= acc;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (acc <= WORD_MAX && acc >= WORD_MIN))
    else $error("accumulator outside word range");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result during store clear");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt < 5'd17))
    else $error("divider overran");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result not from completion");

endmodule
